@@ rtl/core/qicc_pkg.sv @@
package qicc_pkg;

  // Rounding step and correction field widths
  localparam int STEP_WIDTH = 17;
  localparam int HALF_WIDTH = STEP_WIDTH - 1;
  localparam int CORR_WIDTH = 17;

  // Sample payload widths
  localparam int NEW_COUNT_WIDTH = 32;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 17;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_COUNTS_PER_INDEX = 2'd0,
    CFG_REVERSE_POLARITY = 2'd1,
    CFG_INDEX_ENABLE     = 2'd2
  } cfg_index_t;

  localparam logic [STEP_WIDTH-1:0] STEP_MIN   = 17'd4;
  localparam logic [STEP_WIDTH-1:0] STEP_MAX   = 17'd65536;
  localparam logic [STEP_WIDTH-1:0] STEP_RESET = 17'd4096;

  // Request kinds
  localparam logic CMD_SAMPLE    = 1'b0;
  localparam logic CMD_SET_COUNT = 1'b1;

  // Quadrature phase difference codes
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIVIDE,
    ST_FIX,
    ST_EMIT
  } state_t;

  // 00 -> 0, 10 -> 1, 11 -> 2, 01 -> 3
  function automatic logic [1:0] qicc_phase(input logic a, input logic b);
    logic [1:0] p;
    if (a) begin
      p = b ? 2'd2 : 2'd1;
    end else begin
      p = b ? 2'd3 : 2'd0;
    end
    return p;
  endfunction

endpackage

@@ rtl/core/qicc_sample_if.sv @@
interface qicc_sample_if;
  import qicc_pkg::*;

  logic                              valid;
  logic                              ready;
  logic                              command;
  logic                              a_level;
  logic                              b_level;
  logic                              z_level;
  logic signed [NEW_COUNT_WIDTH-1:0] new_count;

  modport source (
    output valid, command, a_level, b_level, z_level, new_count,
    input  ready
  );

  modport sink (
    input  valid, command, a_level, b_level, z_level, new_count,
    output ready
  );

endinterface

@@ rtl/core/qicc_result_if.sv @@
interface qicc_result_if #(
  parameter int POSITION_WIDTH    = 48,
  parameter int INDEX_COUNT_WIDTH = 32
);
  import qicc_pkg::*;

  logic                             valid;
  logic                             ready;
  logic signed [POSITION_WIDTH-1:0] position;
  logic [INDEX_COUNT_WIDTH-1:0]     index_total;
  logic signed [CORR_WIDTH-1:0]     last_correction;

  modport source (
    output valid, position, index_total, last_correction,
    input  ready
  );

  modport sink (
    input  valid, position, index_total, last_correction,
    output ready
  );

endinterface

@@ rtl/core/qicc_cfg_if.sv @@
interface qicc_cfg_if;
  import qicc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );

endinterface

@@ rtl/core/qicc_rem_unit.sv @@
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
module qicc_rem_unit #(
  parameter int DIVIDEND_WIDTH = 49
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [DIVIDEND_WIDTH-1:0]           dividend,
  input  logic [qicc_pkg::STEP_WIDTH-1:0]     divisor,
  output logic                                done,
  output logic [qicc_pkg::STEP_WIDTH-1:0]     remainder
);
  import qicc_pkg::*;

  localparam int COUNT_WIDTH = $clog2(DIVIDEND_WIDTH + 1);
  localparam logic [COUNT_WIDTH-1:0] BIT_COUNT = COUNT_WIDTH'(DIVIDEND_WIDTH);
  localparam logic [COUNT_WIDTH-1:0] LAST_BIT  = COUNT_WIDTH'(1);

  logic [DIVIDEND_WIDTH-1:0] work;
  logic [STEP_WIDTH-1:0]     rem;
  logic [COUNT_WIDTH-1:0]    count;
  logic                      busy;
  logic [STEP_WIDTH:0]       trial;
  logic [STEP_WIDTH:0]       trial_diff;
  logic                      fits;

  assign trial      = {rem, work[DIVIDEND_WIDTH-1]};
  assign trial_diff = trial - {1'b0, divisor};
  assign fits       = trial >= {1'b0, divisor};
  assign remainder  = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= BIT_COUNT;
      end else if (busy) begin
        count <= count - LAST_BIT;
        if (count == LAST_BIT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (busy) begin
      work <= work << 1;
      rem  <= fits ? trial_diff[STEP_WIDTH-1:0] : trial[STEP_WIDTH-1:0];
    end
  end

endmodule

@@ rtl/core/quadrature_index_corrected_counter_top.sv @@
// Quadrature encoder counter with index correction.
//
// sample : one request per pin sample (command = 0, A/B/Z levels) or per
//          set-count (command = 1, new_count). Taken when valid and ready.
// result : one item per request: reported position, index pulse total and
//          the counts added at the latest index correction.
// cfg    : register writes (0 counts_per_index, 1 reverse_polarity,
//          2 index_enable); always ready, other indexes are dropped.
//
// Sequence: a plain sample or set-count is accepted, then loads the result
// register. A sample carrying a rising Z edge with index enabled is accepted,
// prepared, run through a bit-serial remainder unit that retires one dividend
// bit per cycle over POSITION_WIDTH + 1 bits, fixed, then loaded. No new
// request is taken before the current one reaches the result register.
// The result register parts the two sides: the next request is accepted
// while a result still waits; if the receiver stalls, the following result
// holds in the sequencer and sample.ready stays low until the slot frees.
// Reset (rst, synchronous) clears position, offset, index total, last
// correction and the previous pin levels, and restores the register defaults.
module quadrature_index_corrected_counter_top #(
  parameter int POSITION_WIDTH    = 48,
  parameter int INDEX_COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  qicc_sample_if.sink   sample,
  qicc_result_if.source result,
  qicc_cfg_if.sink      cfg
);
  import qicc_pkg::*;

  localparam int DIVIDEND_WIDTH = POSITION_WIDTH + 1;
  localparam logic [INDEX_COUNT_WIDTH-1:0] INDEX_ONE = INDEX_COUNT_WIDTH'(1);

  // Configuration registers
  logic [STEP_WIDTH-1:0] counts_per_index;
  logic                  reverse_polarity;
  logic                  index_enable;

  // Counter state
  logic [POSITION_WIDTH-1:0]    raw_position;
  logic [POSITION_WIDTH-1:0]    pos_offset;
  logic [INDEX_COUNT_WIDTH-1:0] index_counter;
  logic [CORR_WIDTH-1:0]        correction;
  logic                         prev_a;
  logic                         prev_b;
  logic                         prev_z;

  state_t state;
  state_t state_next;

  // Sequencer outputs
  logic accept;
  logic rem_start;
  logic fix_en;
  logic result_load;

  // Datapath signals
  logic [STEP_WIDTH-1:0]     step;
  logic [HALF_WIDTH-1:0]     half_step;
  logic [1:0]                step_dir;
  logic                      index_edge;
  logic [POSITION_WIDTH-1:0] new_count_ext;
  logic                      raw_neg;
  logic [DIVIDEND_WIDTH-1:0] dividend;
  logic                      rem_done;
  logic [STEP_WIDTH-1:0]     remainder;
  logic [STEP_WIDTH:0]       delta_wide;
  logic [POSITION_WIDTH-1:0] delta_ext;
  logic [INDEX_COUNT_WIDTH-1:0] index_next;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_index <= STEP_RESET;
      reverse_polarity <= 1'b0;
      index_enable     <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_COUNTS_PER_INDEX: counts_per_index <= cfg.data[STEP_WIDTH-1:0];
        CFG_REVERSE_POLARITY: reverse_polarity <= cfg.data[0];
        CFG_INDEX_ENABLE:     index_enable     <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Clamp the rounding step to its legal range
  always_comb begin
    priority if (counts_per_index < STEP_MIN) begin
      step = STEP_MIN;
    end else if (counts_per_index > STEP_MAX) begin
      step = STEP_MAX;
    end else begin
      step = counts_per_index;
    end
  end

  assign half_step = step[STEP_WIDTH-1:1];

  // ---------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------
  // x4 decode: phase difference of 1 counts up, 3 counts down, else nothing
  assign step_dir = qicc_phase(sample.a_level, sample.b_level)
                  - qicc_phase(prev_a, prev_b);
  assign index_edge    = index_enable && sample.z_level && !prev_z;
  assign new_count_ext = POSITION_WIDTH'(sample.new_count);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample.valid) begin
          if (sample.command == CMD_SAMPLE && index_edge) begin
            state_next = ST_PREP;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_PREP:   state_next = ST_DIVIDE;
      ST_DIVIDE: if (rem_done) state_next = ST_FIX;
      ST_FIX:    state_next = ST_EMIT;
      ST_EMIT:   if (!result.valid || result.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = 1'b0;
    rem_start    = 1'b0;
    fix_en       = 1'b0;
    result_load  = 1'b0;
    unique case (state)
      ST_IDLE:   sample.ready = 1'b1;
      ST_PREP:   rem_start    = 1'b1;
      ST_DIVIDE: ;
      ST_FIX:    fix_en       = 1'b1;
      ST_EMIT:   result_load  = !result.valid || result.ready;
      default: ;
    endcase
  end

  assign accept = sample.valid && sample.ready;

  // ---------------------------------------------------------------------
  // Index rounding
  // ---------------------------------------------------------------------
  // Dividend is |raw| + step/2; for a negative raw use ~raw + (step/2 + 1)
  assign raw_neg  = raw_position[POSITION_WIDTH-1];
  assign dividend = raw_neg
                  ? {1'b0, ~raw_position} + DIVIDEND_WIDTH'({1'b0, half_step} + 17'd1)
                  : {1'b0, raw_position} + DIVIDEND_WIDTH'(half_step);

  qicc_rem_unit #(
    .DIVIDEND_WIDTH(DIVIDEND_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (dividend),
    .divisor  (step),
    .done     (rem_done),
    .remainder(remainder)
  );

  // Distance to the nearest multiple is step/2 - remainder, negated when raw is negative
  assign delta_wide = raw_neg ? ({1'b0, remainder} - {2'b00, half_step})
                              : ({2'b00, half_step} - {1'b0, remainder});
  assign delta_ext  = POSITION_WIDTH'($signed(delta_wide));
  assign index_next = index_counter + INDEX_ONE;

  // ---------------------------------------------------------------------
  // Counter state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_position  <= '0;
      pos_offset    <= '0;
      index_counter <= '0;
      correction    <= '0;
      prev_a        <= 1'b0;
      prev_b        <= 1'b0;
      prev_z        <= 1'b0;
    end else if (accept) begin
      if (sample.command == CMD_SET_COUNT) begin
        // Move the offset so the reported count equals new_count
        pos_offset <= reverse_polarity ? new_count_ext + raw_position
                                       : new_count_ext - raw_position;
      end else begin
        if (step_dir == DIR_UP) begin
          raw_position <= raw_position + POSITION_WIDTH'(1);
        end else if (step_dir == DIR_DOWN) begin
          raw_position <= raw_position - POSITION_WIDTH'(1);
        end
        prev_a <= sample.a_level;
        prev_b <= sample.b_level;
        prev_z <= sample.z_level;
      end
    end else if (fix_en) begin
      raw_position  <= raw_position + delta_ext;
      correction    <= delta_wide[CORR_WIDTH-1:0];
      index_counter <= index_next;
      // Absorb the first correction so the reported count does not jump
      if (index_next == INDEX_ONE) begin
        pos_offset <= reverse_polarity ? pos_offset + delta_ext
                                       : pos_offset - delta_ext;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (result_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.position        <= reverse_polarity ? pos_offset - raw_position
                                                 : pos_offset + raw_position;
      result.index_total     <= index_counter;
      result.last_correction <= correction;
    end
  end

endmodule

@@ dv/quadrature_index_corrected_counter_top_tb.sv @@
`timescale 1ns / 100ps

module quadrature_index_corrected_counter_top_tb;
  import qicc_pkg::*;

  localparam int POS_W          = 48;
  localparam int IDX_W          = 32;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = POS_W + 10;

  typedef struct packed {
    logic                       command;
    logic                       a_level;
    logic                       b_level;
    logic                       z_level;
    logic [NEW_COUNT_WIDTH-1:0] new_count;
  } sample_request_t;

  typedef struct packed {
    logic [POS_W-1:0]      position;
    logic [IDX_W-1:0]      index_total;
    logic [CORR_WIDTH-1:0] last_correction;
  } count_result_t;

  logic clk;
  logic rst;

  qicc_sample_if sample_bus ();
  qicc_result_if #(.POSITION_WIDTH(POS_W), .INDEX_COUNT_WIDTH(IDX_W)) result_bus ();
  qicc_cfg_if cfg_bus ();

  quadrature_index_corrected_counter_top #(
    .POSITION_WIDTH    (POS_W),
    .INDEX_COUNT_WIDTH (IDX_W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // Register copies, updated when a write is accepted on the cfg port.
  logic [STEP_WIDTH-1:0] reg_counts_per_index = STEP_RESET;
  logic                  reg_reverse          = 1'b0;
  logic                  reg_index_enable     = 1'b1;

  // Counter state as the block should hold it after every accepted request.
  logic [POS_W-1:0]      cnt_raw         = '0;
  logic [POS_W-1:0]      cnt_offset      = '0;
  logic [IDX_W-1:0]      cnt_index_total = '0;
  logic [CORR_WIDTH-1:0] cnt_last_corr   = '0;
  logic                  cnt_prev_a      = 1'b0;
  logic                  cnt_prev_b      = 1'b0;
  logic                  cnt_prev_z      = 1'b0;

  count_result_t expected_counts[$];

  // Idling knobs and the long receiver hold-off handshake between processes.
  int send_idle_pct    = 0;
  int recv_stall_pct   = 0;
  int holdoff_requests = 0;
  int holdoff_seen     = 0;
  int holdoff_left     = 0;

  int requests_sent  = 0;
  int set_commands   = 0;
  int index_events   = 0;
  int results_seen   = 0;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #5_000_000;
    $display("** quadrature_index_corrected_counter_top: FAILED **");
    $finish;
  end

  // Gray phase of the A,B pair: 00 -> 0, 10 -> 1, 11 -> 2, 01 -> 3.
  function automatic logic [1:0] quad_phase(input logic a, input logic b);
    return {b, a ^ b};
  endfunction

  // Advance the counter state by one request and return the result it yields.
  function automatic count_result_t predict_count(input sample_request_t req);
    count_result_t    res;
    logic [1:0]       turn;
    logic [63:0]      round_step;
    logic [63:0]      mag;
    logic [63:0]      rounded;
    logic [63:0]      delta;
    logic [POS_W-1:0] neg_raw;
    logic [POS_W-1:0] wide_count;
    logic             neg;
    neg_raw = -cnt_raw;
    if (req.command == CMD_SET_COUNT) begin
      // Pins are not looked at; only the offset moves.
      wide_count = {{(POS_W - NEW_COUNT_WIDTH){req.new_count[NEW_COUNT_WIDTH-1]}},
                    req.new_count};
      cnt_offset = wide_count - (reg_reverse ? neg_raw : cnt_raw);
    end else begin
      // Decode A/B first, then apply any index correction on the same sample.
      turn = quad_phase(req.a_level, req.b_level) - quad_phase(cnt_prev_a, cnt_prev_b);
      if (turn == DIR_UP) begin
        cnt_raw = cnt_raw + 1'b1;
      end else if (turn == DIR_DOWN) begin
        cnt_raw = cnt_raw - 1'b1;
      end
      if (reg_index_enable && req.z_level && !cnt_prev_z) begin
        if (reg_counts_per_index < STEP_MIN) begin
          round_step = 64'(STEP_MIN);
        end else if (reg_counts_per_index > STEP_MAX) begin
          round_step = 64'(STEP_MAX);
        end else begin
          round_step = 64'(reg_counts_per_index);
        end
        // Round the magnitude to the nearest step, halves away from zero.
        neg     = cnt_raw[POS_W-1];
        neg_raw = -cnt_raw;
        mag     = neg ? 64'(neg_raw) : 64'(cnt_raw);
        rounded = ((mag + round_step / 2) / round_step) * round_step;
        delta   = neg ? mag - rounded : rounded - mag;
        cnt_index_total = cnt_index_total + 1'b1;
        cnt_last_corr   = delta[CORR_WIDTH-1:0];
        cnt_raw         = cnt_raw + delta[POS_W-1:0];
        // Absorb the correction into the offset whenever the total becomes one.
        if (cnt_index_total == 1) begin
          cnt_offset = reg_reverse ? cnt_offset + delta[POS_W-1:0]
                                   : cnt_offset - delta[POS_W-1:0];
        end
        index_events++;
      end
      cnt_prev_a = req.a_level;
      cnt_prev_b = req.b_level;
      cnt_prev_z = req.z_level;
    end
    neg_raw             = -cnt_raw;
    res.position        = (reg_reverse ? neg_raw : cnt_raw) + cnt_offset;
    res.index_total     = cnt_index_total;
    res.last_correction = cnt_last_corr;
    return res;
  endfunction

  function automatic sample_request_t pin_request(input logic a, input logic b, input logic z);
    sample_request_t req;
    req.command   = CMD_SAMPLE;
    req.a_level   = a;
    req.b_level   = b;
    req.z_level   = z;
    req.new_count = $urandom;
    return req;
  endfunction

  function automatic sample_request_t set_request(input logic [NEW_COUNT_WIDTH-1:0] value);
    sample_request_t req;
    req.command   = CMD_SET_COUNT;
    req.a_level   = 1'($urandom_range(1));
    req.b_level   = 1'($urandom_range(1));
    req.z_level   = 1'($urandom_range(1));
    req.new_count = value;
    return req;
  endfunction

  function automatic void note_mismatch(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field, want, got);
    end
  endfunction

  // Offer one request, honoring the sender idle rate, and hold it until taken.
  // Entered and left on a rising edge; valid stays high when the next request
  // follows without a gap.
  task automatic issue_request(input sample_request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sample_bus.valid     <= 1'b1;
    sample_bus.command   <= req.command;
    sample_bus.a_level   <= req.a_level;
    sample_bus.b_level   <= req.b_level;
    sample_bus.z_level   <= req.z_level;
    sample_bus.new_count <= req.new_count;
    do @(posedge clk); while (!sample_bus.ready);
    expected_counts.push_back(predict_count(req));
    requests_sent++;
    if (req.command == CMD_SET_COUNT) set_commands++;
  endtask

  // Drop valid and hold until every expected result is back.
  task automatic drain_results();
    sample_bus.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    unique case (idx)
      CFG_COUNTS_PER_INDEX: reg_counts_per_index = value[STEP_WIDTH-1:0];
      CFG_REVERSE_POLARITY: reg_reverse          = value[0];
      CFG_INDEX_ENABLE:     reg_index_enable     = value[0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reconfigure only once the block is idle.
  task automatic configure(input logic [CFG_DATA_WIDTH-1:0] counts, input logic reverse,
                           input logic enable);
    drain_results();
    write_register(CFG_COUNTS_PER_INDEX, counts);
    write_register(CFG_REVERSE_POLARITY, {{(CFG_DATA_WIDTH - 1){1'b0}}, reverse});
    write_register(CFG_INDEX_ENABLE, {{(CFG_DATA_WIDTH - 1){1'b0}}, enable});
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Walk the encoder: mostly legal steps in runs, with stalls, double changes,
  // Z pulses and set-count commands mixed in. Optionally start a long receiver
  // hold-off half way through while requests keep coming.
  task automatic run_random_stream(input int count, input bit with_holdoff);
    sample_request_t req;
    logic [1:0]      ph;
    logic            z_hold;
    bit              walk_up;
    int              kind;
    z_hold  = cnt_prev_z;
    walk_up = 1'($urandom_range(1));
    for (int i = 0; i < count; i++) begin
      if (with_holdoff && i == count / 2) holdoff_requests <= holdoff_requests + 1;
      ph = quad_phase(cnt_prev_a, cnt_prev_b);
      if ($urandom_range(9) == 0) walk_up = !walk_up;
      if (z_hold) begin
        z_hold = ($urandom_range(1) == 0);
      end else begin
        z_hold = ($urandom_range(99) < 12);
      end
      kind = $urandom_range(99);
      if (kind < 8) begin
        req = set_request($urandom);
      end else begin
        if (kind >= 23) begin
          ph = walk_up ? ph + 2'd1 : ph - 2'd1;
        end else if (kind >= 16) begin
          ph = ph + 2'd2;
        end
        req = pin_request(ph[1] ^ ph[0], ph[1], z_hold);
      end
      issue_request(req);
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (holdoff_seen != holdoff_requests) begin
      holdoff_seen = holdoff_requests;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin : check_results
    count_result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      results_seen++;
      if (expected_counts.size() == 0) begin
        note_mismatch("unexpected result", '0, 64'($unsigned(result_bus.position)));
      end else begin
        want = expected_counts.pop_front();
        if (result_bus.position !== want.position)
          note_mismatch("position", 64'(want.position),
                        64'($unsigned(result_bus.position)));
        if (result_bus.index_total !== want.index_total)
          note_mismatch("index_total", 64'(want.index_total),
                        64'(result_bus.index_total));
        if (result_bus.last_correction !== want.last_correction)
          note_mismatch("last_correction", 64'(want.last_correction),
                        64'($unsigned(result_bus.last_correction)));
      end
    end
  end

  // Default registers. The first sample is compared with 00, so 11 is a
  // double change. Then step up, down past zero, and repeat a sample.
  task automatic test_pin_decode();
    issue_request(pin_request(1'b1, 1'b1, 1'b0));
    issue_request(pin_request(1'b0, 1'b0, 1'b0));
    issue_request(pin_request(1'b1, 1'b0, 1'b0));
    issue_request(pin_request(1'b1, 1'b1, 1'b0));
    issue_request(pin_request(1'b1, 1'b0, 1'b0));
    issue_request(pin_request(1'b0, 1'b0, 1'b0));
    issue_request(pin_request(1'b0, 1'b1, 1'b0));
    issue_request(pin_request(1'b0, 1'b1, 1'b0));
  endtask

  // First index under reversed polarity with a step below the minimum: the
  // same sample steps down to -2, which rounds away from zero to -4, and the
  // offset absorbs it. Bracket it with set-counts at the 32-bit extremes.
  task automatic test_first_index();
    configure('0, 1'b1, 1'b1);
    issue_request(set_request(32'h8000_0000));
    issue_request(pin_request(1'b1, 1'b1, 1'b1));
    issue_request(set_request(32'h7FFF_FFFF));
    issue_request(pin_request(1'b1, 1'b1, 1'b0));
  endtask

  // Later indexes leave the offset alone; Z is ignored while disabled but its
  // level still tracks; an oversized step is clamped to the maximum.
  task automatic test_index_rounding();
    configure(17'd6, 1'b0, 1'b1);
    issue_request(pin_request(1'b1, 1'b0, 1'b1));
    configure(17'd6, 1'b0, 1'b0);
    issue_request(pin_request(1'b1, 1'b0, 1'b0));
    issue_request(pin_request(1'b1, 1'b0, 1'b1));
    configure(17'h1FFFF, 1'b0, 1'b1);
    issue_request(pin_request(1'b1, 1'b0, 1'b1));
    issue_request(pin_request(1'b1, 1'b0, 1'b0));
    issue_request(pin_request(1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_set_count();
    configure(STEP_MAX, 1'b1, 1'b1);
    issue_request(set_request('0));
    issue_request(set_request('1));
    issue_request(pin_request(1'b0, 1'b1, 1'b0));
  endtask

  // Fill the block with the receiver held off, then pause until it drains.
  task automatic test_backpressure();
    configure(17'd8, 1'b0, 1'b1);
    set_idling(0, 0);
    run_random_stream(40, 1'b1);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int send_pct[4];
    int recv_pct[4];
    logic [CFG_DATA_WIDTH-1:0] counts;
    send_pct = '{0, 88, 0, 8};
    recv_pct = '{0, 0, 88, 8};
    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(7))
        0:       counts = '0;
        1:       counts = 17'd3;
        2:       counts = STEP_MIN;
        3:       counts = STEP_MAX;
        4:       counts = '1;
        5:       counts = CFG_DATA_WIDTH'($urandom);
        default: counts = CFG_DATA_WIDTH'($urandom_range(24, 4));
      endcase
      configure(counts, 1'($urandom_range(1)), $urandom_range(9) != 0);
      set_idling(send_pct[p], recv_pct[p]);
      run_random_stream(115, p == 2);
    end
  endtask

  initial begin
    rst                  = 1'b1;
    sample_bus.valid     = 1'b0;
    sample_bus.command   = CMD_SAMPLE;
    sample_bus.a_level   = 1'b0;
    sample_bus.b_level   = 1'b0;
    sample_bus.z_level   = 1'b0;
    sample_bus.new_count = '0;
    result_bus.ready     = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = CFG_COUNTS_PER_INDEX;
    cfg_bus.data         = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_pin_decode();
    test_first_index();
    test_index_rounding();
    test_set_count();
    test_backpressure();
    test_random_traffic();

    // Let any stray result show up before judging.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests (%0d set-count), %0d index corrections.",
             requests_sent, set_commands, index_events);
    $display("Results compared: %0d, mismatches: %0d.", results_seen, mismatch_count);
    if (mismatch_count == 0 && expected_counts.size() == 0) begin
      $display("** quadrature_index_corrected_counter_top: PASSED **");
    end else begin
      $display("** quadrature_index_corrected_counter_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/qicc_pkg.sv
rtl/core/qicc_sample_if.sv
rtl/core/qicc_result_if.sv
rtl/core/qicc_cfg_if.sv
rtl/core/qicc_rem_unit.sv
rtl/core/quadrature_index_corrected_counter_top.sv
dv/quadrature_index_corrected_counter_top_tb.sv
